/* hdl/mtp_pkg.sv */
// Shared types, sizes and saturating helpers for the Markov transition predictor.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package mtp_pkg;

   localparam int NUM_SYMBOLS    = 16;
   localparam int COUNT_BITS     = 32;
   localparam int TALLY_BITS     = 32;
   localparam int FIELD_SYM_BITS = 4;
   localparam int SYM_BITS       = $clog2(NUM_SYMBOLS);
   localparam int ADDR_BITS      = 2 * SYM_BITS;
   localparam int ENTRIES        = NUM_SYMBOLS * NUM_SYMBOLS;

   localparam logic [TALLY_BITS-1:0] WARMUP_RESET = TALLY_BITS'(1000);

   typedef logic [SYM_BITS-1:0]   sym_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [TALLY_BITS-1:0] tally_type;

   // One read beat returning from the count store
   typedef struct packed {
      logic    valid;
      sym_type col;
   } scan_ctl_type;

   // Row scan outcome: first least, first greatest, and the count at the new symbol
   typedef struct packed {
      sym_type   lo_idx;
      sym_type   hi_idx;
      count_type hit_count;
   } scan_result_type;

   function automatic tally_type sat_inc_tally(input tally_type v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic count_type sat_inc_count(input count_type v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

endpackage

/* hdl/mtp_count_store.sv */
// Transition count memory: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses mtp_pkg.
`timescale 1ns / 1ps

module mtp_count_store (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  mtp_pkg::addr_type rd_addr,
   input  logic              wr_en,
   input  mtp_pkg::addr_type wr_addr,
   input  mtp_pkg::count_type wr_data,
   output mtp_pkg::count_type rd_data
);
   import mtp_pkg::*;

   count_type          mem [ENTRIES];
   logic [ENTRIES-1:0] vld_ff;
   logic [ENTRIES-1:0] vld_in;
   count_type          rd_q_ff;
   logic               rd_vld_ff;
   logic               rd_vld_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      vld_in    = vld_ff;
      rd_vld_in = rd_vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
      if (rd_en) begin
         rd_vld_in = vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

/* hdl/mtp_row_scan.sv */
// Running first-min / first-max tracker over one row read out of the count store.
// Also captures the count at the target column. Uses mtp_pkg.
`timescale 1ns / 1ps

module mtp_row_scan (
   input  logic                     clock,
   input  mtp_pkg::scan_ctl_type    ctl,
   input  mtp_pkg::sym_type         target,
   input  mtp_pkg::count_type       rd_data,
   output mtp_pkg::scan_result_type result
);
   import mtp_pkg::*;

   count_type lo_ff, lo_in;
   count_type hi_ff, hi_in;
   sym_type   lo_idx_ff, lo_idx_in;
   sym_type   hi_idx_ff, hi_idx_in;
   count_type hit_count_ff, hit_count_in;

   always_comb begin
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      lo_idx_in    = lo_idx_ff;
      hi_idx_in    = hi_idx_ff;
      hit_count_in = hit_count_ff;
      if (ctl.valid) begin
         // first column seeds both trackers; strict compares keep the lowest index on ties
         if (ctl.col == '0) begin
            lo_in     = rd_data;
            hi_in     = rd_data;
            lo_idx_in = '0;
            hi_idx_in = '0;
         end else begin
            if (rd_data < lo_ff) begin
               lo_in     = rd_data;
               lo_idx_in = ctl.col;
            end
            if (rd_data > hi_ff) begin
               hi_in     = rd_data;
               hi_idx_in = ctl.col;
            end
         end
         if (ctl.col == target) begin
            hit_count_in = rd_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      lo_idx_ff    <= lo_idx_in;
      hi_idx_ff    <= hi_idx_in;
      hit_count_ff <= hit_count_in;
   end

   assign result.lo_idx    = lo_idx_ff;
   assign result.hi_idx    = hi_idx_ff;
   assign result.hit_count = hit_count_ff;

endmodule

/* hdl/markov_transition_predictor_top.sv */
// Top level of the Markov transition predictor: sequencer, tallies, result register.
// Instantiates mtp_count_store and mtp_row_scan; uses mtp_pkg.
//
//   channel | ports                         | direction | handshake
//   req     | req_symbol                    | in        | req_valid / req_ready
//   rsp     | rsp_scored .. rsp_most_miss_* | out       | rsp_valid / rsp_ready
//   csr     | csr_wr_data                   | in        | csr_wr_en, no wait
//
// Each item passes through accept, a read of the previous symbol's row, column by column,
// through the single read port of the count store, a drain for the read latency, and write-back.
// Reset clears all counts (valid bits), tallies, item count and previous symbol at once.
// A result waiting on rsp_ready holds the write-back stage; req_ready is high only when idle.
`timescale 1ns / 1ps

module markov_transition_predictor_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_symbol,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scored,
   output logic [3:0]  rsp_least_guess,
   output logic [3:0]  rsp_most_guess,
   output logic        rsp_least_hit,
   output logic        rsp_most_hit,
   output logic [31:0] rsp_least_hit_total,
   output logic [31:0] rsp_least_miss_total,
   output logic [31:0] rsp_most_hit_total,
   output logic [31:0] rsp_most_miss_total,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import mtp_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_WRITE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   sym_type   col_ff, col_in;
   sym_type   prev_ff, prev_in;
   sym_type   sym_ff, sym_in;
   logic      scored_ff, scored_in;
   tally_type items_ff, items_in;
   tally_type warmup_ff, warmup_in;
   tally_type least_hits_ff, least_hits_in;
   tally_type least_misses_ff, least_misses_in;
   tally_type most_hits_ff, most_hits_in;
   tally_type most_misses_ff, most_misses_in;
   scan_ctl_type rd_ctl_ff, rd_ctl_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_scored_ff;
   logic [FIELD_SYM_BITS-1:0] rsp_least_guess_ff;
   logic [FIELD_SYM_BITS-1:0] rsp_most_guess_ff;
   logic                      rsp_least_hit_ff;
   logic                      rsp_most_hit_ff;

   logic            req_fire;
   logic            write_fire;
   logic            lo_hit;
   logic            hi_hit;
   sym_type         req_sym;
   tally_type       items_next;
   count_type       rd_data;
   scan_result_type scan_res;

   mtp_count_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (state_ff == ST_READ),
      .rd_addr ({prev_ff, col_ff}),
      .wr_en   (write_fire),
      .wr_addr ({prev_ff, sym_ff}),
      .wr_data (sat_inc_count(scan_res.hit_count)),
      .rd_data (rd_data)
   );

   mtp_row_scan u_scan (
      .clock   (clock),
      .ctl     (rd_ctl_ff),
      .target  (sym_ff),
      .rd_data (rd_data),
      .result  (scan_res)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign write_fire = (state_ff == ST_WRITE) && (!rsp_valid_ff || rsp_ready);

   // clamp symbols beyond the alphabet to its last index
   assign req_sym = (32'(req_symbol) >= NUM_SYMBOLS) ? SYM_BITS'(NUM_SYMBOLS - 1)
                                                      : SYM_BITS'(req_symbol);
   assign items_next = sat_inc_tally(items_ff);

   assign lo_hit = scored_ff && (sym_ff == scan_res.lo_idx);
   assign hi_hit = scored_ff && (sym_ff == scan_res.hi_idx);

   always_comb begin
      state_in        = state_ff;
      col_in          = col_ff;
      prev_in         = prev_ff;
      sym_in          = sym_ff;
      scored_in       = scored_ff;
      items_in        = items_ff;
      warmup_in       = csr_wr_en ? csr_wr_data : warmup_ff;
      least_hits_in   = least_hits_ff;
      least_misses_in = least_misses_ff;
      most_hits_in    = most_hits_ff;
      most_misses_in  = most_misses_ff;
      rd_ctl_in.valid = (state_ff == ST_READ);
      rd_ctl_in.col   = col_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               sym_in    = req_sym;
               items_in  = items_next;
               scored_in = (items_next > warmup_ff);
               col_in    = '0;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            if (col_ff == SYM_BITS'(NUM_SYMBOLS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (write_fire) begin
               prev_in  = sym_ff;
               state_in = ST_IDLE;
               if (scored_ff) begin
                  if (lo_hit) least_hits_in = sat_inc_tally(least_hits_ff);
                  else        least_misses_in = sat_inc_tally(least_misses_ff);
                  if (hi_hit) most_hits_in = sat_inc_tally(most_hits_ff);
                  else        most_misses_in = sat_inc_tally(most_misses_ff);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold the result until the transfer; a new one loads only at write-back
   assign rsp_valid_in = write_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         prev_ff         <= '0;
         items_ff        <= '0;
         warmup_ff       <= WARMUP_RESET;
         least_hits_ff   <= '0;
         least_misses_ff <= '0;
         most_hits_ff    <= '0;
         most_misses_ff  <= '0;
         rd_ctl_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         prev_ff         <= prev_in;
         items_ff        <= items_in;
         warmup_ff       <= warmup_in;
         least_hits_ff   <= least_hits_in;
         least_misses_ff <= least_misses_in;
         most_hits_ff    <= most_hits_in;
         most_misses_ff  <= most_misses_in;
         rd_ctl_ff       <= rd_ctl_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff    <= col_in;
      sym_ff    <= sym_in;
      scored_ff <= scored_in;
      if (write_fire) begin
         rsp_scored_ff      <= scored_ff;
         rsp_least_guess_ff <= scored_ff ? FIELD_SYM_BITS'(scan_res.lo_idx) : '0;
         rsp_most_guess_ff  <= scored_ff ? FIELD_SYM_BITS'(scan_res.hi_idx) : '0;
         rsp_least_hit_ff   <= lo_hit;
         rsp_most_hit_ff    <= hi_hit;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_scored           = rsp_scored_ff;
   assign rsp_least_guess      = rsp_least_guess_ff;
   assign rsp_most_guess       = rsp_most_guess_ff;
   assign rsp_least_hit        = rsp_least_hit_ff;
   assign rsp_most_hit         = rsp_most_hit_ff;
   assign rsp_least_hit_total  = least_hits_ff;
   assign rsp_least_miss_total = least_misses_ff;
   assign rsp_most_hit_total   = most_hits_ff;
   assign rsp_most_miss_total  = most_misses_ff;

`ifndef SYNTHESIS
   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_WRITE))
      else $error("result loaded outside write-back");

   a_unscored_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_scored_ff) |->
         (rsp_least_guess_ff == '0 && rsp_most_guess_ff == '0 &&
          !rsp_least_hit_ff && !rsp_most_hit_ff))
      else $error("unscored result carries guesses or hits");

   a_tally_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (least_hits_ff >= $past(least_hits_ff)) &&
               (most_misses_ff >= $past(most_misses_ff)))
      else $error("tally decreased");

   a_tally_only_on_write: assert property (@(posedge clock) disable iff (reset)
      !write_fire |=> $stable(least_hits_ff) && $stable(least_misses_ff) &&
                      $stable(most_hits_ff) && $stable(most_misses_ff))
      else $error("tally changed outside write-back");
`endif

endmodule

/* tb/sv/tb_markov_transition_predictor_top.sv */
// Testbench for markov_transition_predictor_top: directed and biased random symbol streams,
// checked result by result against an in-bench transition-count predictor.
// Depends on mtp_pkg and markov_transition_predictor_top.
`timescale 1ns / 1ps

module tb_markov_transition_predictor_top;

   import mtp_pkg::*;

   localparam int ITEM_CYCLES = 19;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_CAP   = 100;

   typedef struct {
      sym_type symbol;
      bit      drain_first;
   } symbol_item_type;

   typedef struct {
      logic      scored;
      sym_type   least_guess;
      sym_type   most_guess;
      logic      least_hit;
      logic      most_hit;
      tally_type least_hits;
      tally_type least_misses;
      tally_type most_hits;
      tally_type most_misses;
   } guess_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [3:0]  req_symbol = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_scored;
   logic [3:0]  rsp_least_guess;
   logic [3:0]  rsp_most_guess;
   logic        rsp_least_hit;
   logic        rsp_most_hit;
   logic [31:0] rsp_least_hit_total;
   logic [31:0] rsp_least_miss_total;
   logic [31:0] rsp_most_hit_total;
   logic [31:0] rsp_most_miss_total;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   // Predictor state
   count_type trans_count [NUM_SYMBOLS][NUM_SYMBOLS];
   sym_type   last_symbol;
   tally_type items_seen;
   tally_type least_hits, least_misses, most_hits, most_misses;
   tally_type warmup_threshold;

   symbol_item_type  symbol_backlog [$];
   guess_result_type predicted_results [$];
   int               issued_cnt = 0;
   int               accepted_cnt = 0;
   int               error_count = 0;
   int               cycle_count = 0;
   int               send_idle_pct = 29;
   int               recv_idle_pct = 53;
   sym_type          favored_next [NUM_SYMBOLS];
   sym_type          last_generated = '0;

   markov_transition_predictor_top i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_symbol           (req_symbol),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_scored           (rsp_scored),
      .rsp_least_guess      (rsp_least_guess),
      .rsp_most_guess       (rsp_most_guess),
      .rsp_least_hit        (rsp_least_hit),
      .rsp_most_hit         (rsp_most_hit),
      .rsp_least_hit_total  (rsp_least_hit_total),
      .rsp_least_miss_total (rsp_least_miss_total),
      .rsp_most_hit_total   (rsp_most_hit_total),
      .rsp_most_miss_total  (rsp_most_miss_total),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   initial forever #2 clock = ~clock;

   function automatic tally_type bump_tally(input tally_type v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // Score the previous symbol's row against the new symbol, then count the transition.
   function automatic guess_result_type advance_chain(input sym_type symbol);
      guess_result_type res;
      count_type        lo, hi;
      int               j;
      res = '{default: '0};
      items_seen = bump_tally(items_seen);
      res.scored = (items_seen > warmup_threshold);
      if (res.scored) begin
         lo = trans_count[last_symbol][0];
         hi = lo;
         for (j = 1; j < NUM_SYMBOLS; j++) begin
            if (trans_count[last_symbol][j] < lo) begin
               lo = trans_count[last_symbol][j];
               res.least_guess = sym_type'(j);
            end
            if (trans_count[last_symbol][j] > hi) begin
               hi = trans_count[last_symbol][j];
               res.most_guess = sym_type'(j);
            end
         end
         res.least_hit = (symbol == res.least_guess);
         res.most_hit  = (symbol == res.most_guess);
         if (res.least_hit) least_hits = bump_tally(least_hits);
         else least_misses = bump_tally(least_misses);
         if (res.most_hit) most_hits = bump_tally(most_hits);
         else most_misses = bump_tally(most_misses);
      end
      if (trans_count[last_symbol][symbol] != '1)
         trans_count[last_symbol][symbol] = trans_count[last_symbol][symbol] + 1'b1;
      last_symbol = symbol;
      res.least_hits   = least_hits;
      res.least_misses = least_misses;
      res.most_hits    = most_hits;
      res.most_misses  = most_misses;
      return res;
   endfunction

   task automatic report_error(input string msg);
      if (error_count < PRINT_CAP)
         $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_error($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
   endtask

   // Driver: present symbols at the falling edge, hold each until its transfer.
   always @(negedge clock) begin : driver
      symbol_item_type item;
      logic            next_valid;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || accepted_cnt == issued_cnt) begin
         next_valid = 1'b0;
         if (symbol_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct &&
             (!symbol_backlog[0].drain_first || predicted_results.size() == 0)) begin
            item = symbol_backlog.pop_front();
            req_symbol <= item.symbol;
            issued_cnt++;
            next_valid = 1'b1;
         end
      end
      req_valid <= next_valid;
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor: track register writes and transfers on both channels at the rising edge.
   always @(posedge clock) begin : monitor
      guess_result_type want;
      int               r, c;
      if (reset) begin
         for (r = 0; r < NUM_SYMBOLS; r++)
            for (c = 0; c < NUM_SYMBOLS; c++)
               trans_count[r][c] = '0;
         last_symbol      = '0;
         items_seen       = '0;
         least_hits       = '0;
         least_misses     = '0;
         most_hits        = '0;
         most_misses      = '0;
         warmup_threshold = WARMUP_RESET;
      end else begin
         if (csr_wr_en)
            warmup_threshold = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               report_error("result with no prediction pending");
            end else begin
               want = predicted_results.pop_front();
               compare_field("scored", rsp_scored, want.scored);
               compare_field("least_guess", rsp_least_guess, want.least_guess);
               compare_field("most_guess", rsp_most_guess, want.most_guess);
               compare_field("least_hit", rsp_least_hit, want.least_hit);
               compare_field("most_hit", rsp_most_hit, want.most_hit);
               compare_field("least_hit_total", rsp_least_hit_total, want.least_hits);
               compare_field("least_miss_total", rsp_least_miss_total, want.least_misses);
               compare_field("most_hit_total", rsp_most_hit_total, want.most_hits);
               compare_field("most_miss_total", rsp_most_miss_total, want.most_misses);
            end
         end
         if (req_valid && req_ready) begin
            predicted_results.push_back(advance_chain(req_symbol));
            accepted_cnt++;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic wait_drained();
      while (symbol_backlog.size() != 0 || accepted_cnt != issued_cnt || req_valid ||
             predicted_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_warmup(input tally_type value);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly follow a hidden favored successor so rows build clear maxima; else uniform.
   task automatic queue_random(input int count, input int drain_at);
      symbol_item_type item;
      int              k;
      for (k = 0; k < count; k++) begin
         if ($urandom_range(99) < 65)
            item.symbol = favored_next[last_generated];
         else
            item.symbol = sym_type'($urandom_range(NUM_SYMBOLS - 1));
         item.drain_first = (k == drain_at);
         last_generated = item.symbol;
         symbol_backlog.push_back(item);
      end
   endtask

   initial begin : stimulus
      int              opening [3]  = '{7, 8, 15};
      int              directed [22] = '{0, 0, 0, 15, 15, 0, 15, 1, 2, 3, 4, 5, 6, 7,
                                         8, 9, 10, 11, 12, 13, 14, 14};
      symbol_item_type item;
      int              k;
      for (k = 0; k < NUM_SYMBOLS; k++)
         favored_next[k] = sym_type'($urandom_range(NUM_SYMBOLS - 1));
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset threshold: nothing scored yet
      item.drain_first = 1'b0;
      foreach (opening[k]) begin
         item.symbol = sym_type'(opening[k]);
         symbol_backlog.push_back(item);
      end

      // Score from the first item: empty rows, ties, both extremes
      write_warmup('0);
      foreach (directed[k]) begin
         item.symbol = sym_type'(directed[k]);
         symbol_backlog.push_back(item);
      end
      last_generated = sym_type'(directed[21]);

      write_warmup('1);
      queue_random(60, -1);

      // Cross the threshold part way through
      write_warmup(items_seen + 40);
      queue_random(100, -1);

      write_warmup(items_seen);
      send_idle_pct = 53;
      recv_idle_pct = 29;
      queue_random(150, 75);

      write_warmup(items_seen + $urandom_range(10, 40));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(140, -1);

      wait_drained();
      repeat (2 * ITEM_CYCLES) @(posedge clock);
      if (predicted_results.size() != 0)
         report_error($sformatf("%0d predictions left over", predicted_results.size()));
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* filelist.f */
hdl/mtp_pkg.sv
hdl/mtp_count_store.sv
hdl/mtp_row_scan.sv
hdl/markov_transition_predictor_top.sv
tb/sv/tb_markov_transition_predictor_top.sv
